// ===== hdl/s3x3_pkg.sv =====
// Shared types for the 3x3 linear system solver.
// No dependencies; used by s3x3_div and solve_3x3_linear_system.
package s3x3_pkg;

	// Side information that travels with one system through the divider.
	typedef struct packed {
		logic       singular;
		logic [2:0] neg;
	} s3x3_ctl_t;

endpackage

// ===== hdl/s3x3_div.sv =====
// Pipelined restoring divider for the three solution elements, one quotient bit per stage.
// Ends in the saturation logic and the output register. Depends on s3x3_pkg.
module s3x3_div #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [3*DATA_WIDTH+3+FRAC_BITS-1:0]        nabs [3],
	input  logic [3*DATA_WIDTH+2:0]                    dabs,
	input  s3x3_pkg::s3x3_ctl_t                        ctl,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [DATA_WIDTH-1:0]               sol [3],
	output logic                                       singular,
	output logic                                       overflow
);
	import s3x3_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int SW = 3 * DATA_WIDTH + 3;
	localparam int NW = SW + FRAC_BITS;
	localparam int XW = NW + DATA_WIDTH;

	logic [XW-1:0]  rem_s  [W+1][3];
	logic [W-1:0]   quo_s  [W+1][3];
	logic [2:0]     big_s  [W+1];
	logic [SW-1:0]  dabs_s [W+1];
	s3x3_ctl_t      ctl_s  [W+1];
	logic [W:0]     vld_s;
	logic [W+1:0]   adv;
	logic           out_valid_q;

	// A stage may load when it is empty or when the stage after it moves.
	always_comb begin
		adv[W+1] = !out_valid_q || !out_stall;
		for (int k = W; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k <= W; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			if (adv[W+1]) begin
				out_valid_q <= vld_s[W];
			end
		end
	end

	// Stage 0: a quotient of 2^W or more cannot fit and is flagged here.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dabs_s[0] <= dabs;
			ctl_s[0]  <= ctl;
			for (int j = 0; j < 3; j++) begin
				rem_s[0][j] <= XW'(nabs[j]);
				quo_s[0][j] <= '0;
				big_s[0][j] <= XW'(nabs[j]) >= (XW'(dabs) << W);
			end
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 1; k <= W; k++) begin : g_step
		localparam int BIT = W - k;
		logic [XW-1:0] dsh;
		assign dsh = XW'(dabs_s[k-1]) << BIT;
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				dabs_s[k] <= dabs_s[k-1];
				ctl_s[k]  <= ctl_s[k-1];
				big_s[k]  <= big_s[k-1];
				for (int j = 0; j < 3; j++) begin
					quo_s[k][j] <= quo_s[k-1][j];
					if (rem_s[k-1][j] >= dsh) begin
						rem_s[k][j]      <= rem_s[k-1][j] - dsh;
						quo_s[k][j][BIT] <= 1'b1;
					end else begin
						rem_s[k][j] <= rem_s[k-1][j];
					end
				end
			end
		end
	end

	// Saturation and sign.
	logic [W-1:0]            limit [3];
	logic [W-1:0]            mag   [3];
	logic [2:0]              sat;
	logic signed [W-1:0]     sol_d [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			limit[j] = ctl_s[W].neg[j] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			sat[j]   = big_s[W][j] || (quo_s[W][j] > limit[j]);
			mag[j]   = sat[j] ? limit[j] : quo_s[W][j];
			if (ctl_s[W].singular) begin
				sol_d[j] = '0;
			end else if (ctl_s[W].neg[j]) begin
				sol_d[j] = $signed(-mag[j]);
			end else begin
				sol_d[j] = $signed(mag[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[W+1]) begin
			sol      <= sol_d;
			singular <= ctl_s[W].singular;
			overflow <= !ctl_s[W].singular && (|sat);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/solve_3x3_linear_system.sv =====
// Top level of the 3x3 linear system solver (adjugate / Cramer's rule, exact division).
// Depends on s3x3_pkg and s3x3_div.
//
//   channel   direction   handshake             beat contents
//   in        input       in_valid / in_stall   m11..m33, rhs1..rhs3
//   out       output      out_valid / out_stall sol1..sol3, singular, overflow
//
// One system enters per cycle while in_stall is low; a result leaves after its beat has
// passed six arithmetic stages, one range check stage, one stage per quotient bit of
// the divider, and the output register. The quotient bit chain is the bulk of the pipeline.
// Reset clears only the valid bits; the data registers are left alone.
// Each stage holds while the next one is full and stalled, so bubbles are squeezed out
// and a stall on the output reaches the input only once the whole pipeline is full.
module solve_3x3_linear_system #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m13,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	input  logic signed [DATA_WIDTH-1:0] m23,
	input  logic signed [DATA_WIDTH-1:0] m31,
	input  logic signed [DATA_WIDTH-1:0] m32,
	input  logic signed [DATA_WIDTH-1:0] m33,
	input  logic signed [DATA_WIDTH-1:0] rhs1,
	input  logic signed [DATA_WIDTH-1:0] rhs2,
	input  logic signed [DATA_WIDTH-1:0] rhs3,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] sol1,
	output logic signed [DATA_WIDTH-1:0] sol2,
	output logic signed [DATA_WIDTH-1:0] sol3,
	output logic                         singular,
	output logic                         overflow
);
	import s3x3_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * DATA_WIDTH;       // one matrix product
	localparam int CW = 2 * DATA_WIDTH + 1;   // one cofactor
	localparam int HW = 2 * DATA_WIDTH + 1;   // one partial product of a cofactor term
	localparam int SW = 3 * DATA_WIDTH + 3;   // determinant and numerators
	localparam int NW = SW + FRAC_BITS;       // numerators scaled to the output format

	// Pipeline handshake: each stage loads when it is empty or the next one moves.
	logic [6:1] vld_s;
	logic [6:1] adv;
	logic       div_stall;

	always_comb begin
		adv[6] = !vld_s[6] || !div_stall;
		for (int k = 5; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 1: the eighteen 2x2 minor products.
	// Cofactor c = p[0] - p[1], in the order c11, c12, c13, c21, ..., c33.
	logic signed [PW-1:0] pp_s1 [9][2];
	logic signed [W-1:0]  col_s1 [3];   // first matrix column, for the determinant
	logic signed [W-1:0]  rhs_s1 [3];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pp_s1[0][0] <= m33 * m22;  pp_s1[0][1] <= m32 * m23;
			pp_s1[1][0] <= m32 * m13;  pp_s1[1][1] <= m33 * m12;
			pp_s1[2][0] <= m23 * m12;  pp_s1[2][1] <= m22 * m13;
			pp_s1[3][0] <= m31 * m23;  pp_s1[3][1] <= m33 * m21;
			pp_s1[4][0] <= m33 * m11;  pp_s1[4][1] <= m31 * m13;
			pp_s1[5][0] <= m21 * m13;  pp_s1[5][1] <= m23 * m11;
			pp_s1[6][0] <= m32 * m21;  pp_s1[6][1] <= m31 * m22;
			pp_s1[7][0] <= m31 * m12;  pp_s1[7][1] <= m32 * m11;
			pp_s1[8][0] <= m22 * m11;  pp_s1[8][1] <= m21 * m12;
			col_s1[0] <= m11;
			col_s1[1] <= m21;
			col_s1[2] <= m31;
			rhs_s1[0] <= rhs1;
			rhs_s1[1] <= rhs2;
			rhs_s1[2] <= rhs3;
		end
	end

	// Stage 2: cofactors at full precision.
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [W-1:0]  col_s2 [3];
	logic signed [W-1:0]  rhs_s2 [3];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int c = 0; c < 9; c++) begin
				cof_s2[c] <= CW'(pp_s1[c][0]) - CW'(pp_s1[c][1]);
			end
			col_s2 <= col_s1;
			rhs_s2 <= rhs_s1;
		end
	end

	// Stage 3: each cofactor term is split into its low W bits (unsigned) and the
	// signed rest, so that no multiplier is wider than about W+1 bits.
	// Row 0 is the determinant, rows 1 to 3 the numerators of x1 to x3.
	logic signed [HW-1:0] plo_s3 [4][3];
	logic signed [HW-1:0] phi_s3 [4][3];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int t = 0; t < 3; t++) begin
				plo_s3[0][t] <= col_s2[t] * $signed({1'b0, cof_s2[t][W-1:0]});
				phi_s3[0][t] <= col_s2[t] * $signed(cof_s2[t][CW-1:W]);
				for (int r = 1; r < 4; r++) begin
					plo_s3[r][t] <= rhs_s2[t] *
						$signed({1'b0, cof_s2[(r-1)*3+t][W-1:0]});
					phi_s3[r][t] <= rhs_s2[t] * $signed(cof_s2[(r-1)*3+t][CW-1:W]);
				end
			end
		end
	end

	// Stage 4: whole terms.
	logic signed [SW-1:0] term_s4 [4][3];

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int r = 0; r < 4; r++) begin
				for (int t = 0; t < 3; t++) begin
					term_s4[r][t] <= SW'(plo_s3[r][t]) + (SW'(phi_s3[r][t]) <<< W);
				end
			end
		end
	end

	// Stage 5: determinant and the three numerators.
	logic signed [SW-1:0] sum_s5 [4];

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int r = 0; r < 4; r++) begin
				sum_s5[r] <= term_s4[r][0] + term_s4[r][1] + term_s4[r][2];
			end
		end
	end

	// Stage 6: scale the numerators by 2^FRAC_BITS and take magnitudes and signs,
	// so that the divider works on unsigned values and truncates toward zero.
	logic [NW-1:0]        nabs_s6 [3];
	logic [SW-1:0]        dabs_s6;
	s3x3_ctl_t            ctl_s6;
	logic signed [NW-1:0] scaled [3];
	logic                 det_neg;

	always_comb begin
		det_neg = sum_s5[0][SW-1];
		for (int j = 0; j < 3; j++) begin
			scaled[j] = NW'(sum_s5[j+1]) <<< FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			dabs_s6          <= det_neg ? $unsigned(-sum_s5[0]) : $unsigned(sum_s5[0]);
			ctl_s6.singular  <= (sum_s5[0] == '0);
			for (int j = 0; j < 3; j++) begin
				nabs_s6[j]    <= scaled[j][NW-1] ? $unsigned(-scaled[j]) : $unsigned(scaled[j]);
				ctl_s6.neg[j] <= scaled[j][NW-1] != det_neg;
			end
		end
	end

	logic signed [W-1:0] sol_w [3];

	s3x3_div #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s[6]),
		.in_stall  (div_stall),
		.nabs      (nabs_s6),
		.dabs      (dabs_s6),
		.ctl       (ctl_s6),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sol       (sol_w),
		.singular  (singular),
		.overflow  (overflow)
	);

	assign sol1 = sol_w[0];
	assign sol2 = sol_w[1];
	assign sol3 = sol_w[2];

endmodule

// ===== tb/solve_3x3_linear_system_checker.sv =====
// Checker for the 3x3 linear system solver: watches both channels, predicts each solution
// with exact wide integer arithmetic and compares the result beats. Depends on nothing else.
`timescale 1ns / 1ps

module solve_3x3_linear_system_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] m11, m12, m13, m21, m22, m23, m31, m32, m33,
	input  logic signed [31:0] rhs1, rhs2, rhs3,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] sol1, sol2, sol3,
	input  logic               singular,
	input  logic               overflow,
	output int                 mismatches,
	output int                 pending,
	output int                 solved_count,
	output int                 singular_count,
	output int                 overflow_count
);

	typedef struct packed {
		logic signed [31:0] x1, x2, x3;
		logic               sing;
		logic               ovf;
	} solution_t;

	solution_t expected_solutions[$];

	// Exact quotient of n * 2^16 by det, truncated toward zero and saturated to 32 bits.
	function automatic logic signed [31:0] scaled_quotient(logic signed [159:0] n,
			logic signed [159:0] det, inout logic ovf);
		logic signed [159:0] q;
		q = (n <<< 16) / det;
		if (q > 160'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (q < -160'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return q[31:0];
	endfunction

	function automatic solution_t solve_system(logic signed [159:0] a11, a12, a13,
			a21, a22, a23, a31, a32, a33, b1, b2, b3);
		logic signed [159:0] c11, c12, c13, c21, c22, c23, c31, c32, c33, det;
		solution_t s;
		c11 = a33*a22 - a32*a23;  c12 = a32*a13 - a33*a12;  c13 = a23*a12 - a22*a13;
		c21 = a31*a23 - a33*a21;  c22 = a33*a11 - a31*a13;  c23 = a21*a13 - a23*a11;
		c31 = a32*a21 - a31*a22;  c32 = a31*a12 - a32*a11;  c33 = a22*a11 - a21*a12;
		det = a11*c11 + a21*c12 + a31*c13;
		s = '0;
		if (det == 0) begin
			s.sing = 1'b1;
			return s;
		end
		s.x1 = scaled_quotient(c11*b1 + c12*b2 + c13*b3, det, s.ovf);
		s.x2 = scaled_quotient(c21*b1 + c22*b2 + c23*b3, det, s.ovf);
		s.x3 = scaled_quotient(c31*b1 + c32*b2 + c33*b3, det, s.ovf);
		return s;
	endfunction

	task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t e;
		if (!arst_n) begin
			mismatches      = 0;
			solved_count   <= 0;
			singular_count <= 0;
			overflow_count <= 0;
			expected_solutions.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_solutions.push_back(solve_system(m11, m12, m13, m21, m22, m23,
					m31, m32, m33, rhs1, rhs2, rhs3));
			if (out_valid && !out_stall) begin
				solved_count <= solved_count + 1;
				if (singular) singular_count <= singular_count + 1;
				if (overflow) overflow_count <= overflow_count + 1;
				if (expected_solutions.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					mismatches++;
				end else begin
					e = expected_solutions.pop_front();
					if (sol1 !== e.x1) report_mismatch("sol1", sol1, e.x1);
					if (sol2 !== e.x2) report_mismatch("sol2", sol2, e.x2);
					if (sol3 !== e.x3) report_mismatch("sol3", sol3, e.x3);
					if (singular !== e.sing) report_mismatch("singular", singular, e.sing);
					if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
				end
			end
		end
		pending = expected_solutions.size();
	end

endmodule

// ===== tb/solve_3x3_linear_system_tb.sv =====
// Top of the testbench for the 3x3 linear system solver: drives systems into the block,
// stalls its output and gives the verdict. Depends on solve_3x3_linear_system and its checker.
`timescale 1ns / 1ps

module solve_3x3_linear_system_tb;

	localparam int Q_ONE = 32'sh0001_0000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
	logic signed [31:0] rhs1, rhs2, rhs3;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] sol1, sol2, sol3;
	logic               singular;
	logic               overflow;

	int mismatches, pending, solved_count, singular_count, overflow_count;

	// Idling odds in percent; the stimulus process moves through the three phases.
	int send_idle_pct = 18;
	int recv_idle_pct = 48;
	// While set, the receiver process holds the output off for a long stretch.
	bit hold_request = 0;

	solve_3x3_linear_system u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
		.m31(m31), .m32(m32), .m33(m33), .rhs1(rhs1), .rhs2(rhs2), .rhs3(rhs3),
		.out_valid(out_valid), .out_stall(out_stall),
		.sol1(sol1), .sol2(sol2), .sol3(sol3), .singular(singular), .overflow(overflow)
	);

	solve_3x3_linear_system_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.m11(m11), .m12(m12), .m13(m13), .m21(m21), .m22(m22), .m23(m23),
		.m31(m31), .m32(m32), .m33(m33), .rhs1(rhs1), .rhs2(rhs2), .rhs3(rhs3),
		.out_valid(out_valid), .out_stall(out_stall),
		.sol1(sol1), .sol2(sol2), .sol3(sol3), .singular(singular), .overflow(overflow),
		.mismatches(mismatches), .pending(pending), .solved_count(solved_count),
		.singular_count(singular_count), .overflow_count(overflow_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver stalls at random per the current phase. A hold request turns into a
	// long stall counted here, so that the pipeline fills and pushes back on the input.
	initial begin
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (120) @(posedge clk);
				hold_request = 0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// A random word that leans toward the values that stress the arithmetic: the two
	// extremes, zero, plus or minus one in Q16.16, and small or full-range numbers.
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return ($urandom_range(1) != 0) ? Q_ONE : -Q_ONE;
			4, 5: return $signed($urandom_range(2 * Q_ONE * 8)) - Q_ONE * 8;
			6: return $signed($urandom_range(511)) - 256;
			default: return $urandom;
		endcase
	endfunction

	// Offers one system and holds it, unchanged, until the block takes it. Unless random
	// idling drops it first, valid is raised for the next beat in the same step that the previous
	// one is taken, and it is never dropped and raised again in one step.
	task automatic send_system(logic signed [31:0] a[9], logic signed [31:0] b[3]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{m11, m12, m13, m21, m22, m23, m31, m32, m33} <=
			{a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
		{rhs1, rhs2, rhs3} <= {b[0], b[1], b[2]};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_system();
		logic signed [31:0] a[9];
		logic signed [31:0] b[3];
		int shape;
		foreach (a[i]) a[i] = pick_word();
		foreach (b[i]) b[i] = pick_word();
		shape = $urandom_range(9);
		// Some systems are made singular on purpose: a copied row or a zero column.
		if (shape == 0) begin
			a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
		end else if (shape == 1) begin
			a[1] = 0; a[4] = 0; a[7] = 0;
		end else if (shape <= 4) begin
			// Diagonal-heavy systems keep the solution in range most of the time.
			a[0] = Q_ONE * $urandom_range(1, 64); a[4] = -Q_ONE * $urandom_range(1, 64);
			a[8] = Q_ONE * $urandom_range(1, 64);
			a[1] = $signed($urandom_range(2 * Q_ONE)) - Q_ONE;
			a[5] = $signed($urandom_range(2 * Q_ONE)) - Q_ONE;
		end
		send_system(a, b);
	endtask

	initial begin
		logic signed [31:0] a[9];
		logic signed [31:0] b[3];
		arst_n   = 1'b0;
		in_valid = 1'b0;
		{m11, m12, m13, m21, m22, m23, m31, m32, m33} = '0;
		{rhs1, rhs2, rhs3} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The identity gives the right-hand side back.
		a = '{Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE};
		b = '{32'sh7fffffff, 32'sh80000000, -Q_ONE};
		send_system(a, b);
		// A tiny determinant blows the solution up past both limits.
		a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		b = '{32'sh7fffffff, 32'sh80000000, 1};
		send_system(a, b);
		// The all-zero matrix and a matrix with two equal rows are singular.
		a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_system(a, b);
		a = '{Q_ONE, 2, 3, Q_ONE, 2, 3, 5, 6, 7};
		send_system(a, b);
		// Every element at the extremes, with all-ones and all-zero right-hand sides.
		a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff};
		b = '{-1, -1, -1};
		send_system(a, b);
		b = '{0, 0, 0};
		send_system(a, b);
		a = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
		b = '{32'sh80000000, 32'sh7fffffff, 1};
		send_system(a, b);
		// A negative determinant with a result truncated toward zero.
		a = '{-3 * Q_ONE, 0, 0, 0, 3 * Q_ONE, Q_ONE, 0, 0, 7 * Q_ONE};
		b = '{Q_ONE, -Q_ONE, 2};
		send_system(a, b);
		repeat (12) send_random_system();

		// Random part in three idling phases, with long output holds in the first and the third.
		for (int i = 0; i < 1150; i++) begin
			if (i == 380) begin
				send_idle_pct = 48;
				recv_idle_pct = 18;
			end else if (i == 760) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (i == 100 || i == 900) hold_request = 1;
			send_random_system();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d solved systems, %0d singular and %0d saturated",
			solved_count, singular_count, overflow_count);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Roughly 1200 systems under the worst stalls need well under a millisecond.
	initial begin
		#2ms;
		$display("timeout with %0d results outstanding", pending);
		$display("FAIL");
		$finish;
	end

endmodule
